// File: rtl/core/sgt_pkg.sv
// sgt_pkg: field widths, codes and beat types for the stack graph traversal block.
// No dependencies; used by the channel interfaces and by the top level.

package sgt_pkg;

   localparam int VERTEX_W = 6;
   localparam int ROW_W    = 64;
   localparam int COUNT_W  = 7;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   localparam logic KIND_ROW   = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [VERTEX_W-1:0] row_index;
      logic [ROW_W-1:0]    row_bits;
      logic [VERTEX_W-1:0] start_vertex;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last;
      logic                bad_start;
   } rsp_type;

endpackage

// File: rtl/core/sgt_req_if.sv
// sgt_req_if: valid/ready channel for request beats (row loads and starts).
// Depends on sgt_pkg.

interface sgt_req_if;
   import sgt_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sgt_rsp_if.sv
// sgt_rsp_if: valid/ready channel for response beats (visited vertices).
// Depends on sgt_pkg.

interface sgt_rsp_if;
   import sgt_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sgt_msb_pick.sv
// sgt_msb_pick: finds the highest set bit of a vector, without a priority chain.
// Standalone; used by stack_graph_traversal for the neighbor scan.

module sgt_msb_pick #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         vec,
   output logic [$clog2(WIDTH)-1:0] idx,
   output logic                     found
);
   localparam int IDX_W = $clog2(WIDTH);

   logic [WIDTH-1:0] rev;
   logic [WIDTH-1:0] low;
   logic [WIDTH-1:0] hot;

   // highest bit of vec is the lowest bit of the reversed vector: r & -r
   always_comb begin
      for (int i = 0; i < WIDTH; i++) begin
         rev[i] = vec[WIDTH-1-i];
      end
      low = rev & (~rev + WIDTH'(1));
      for (int i = 0; i < WIDTH; i++) begin
         hot[i] = low[WIDTH-1-i];
      end
   end

   always_comb begin
      idx = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (hot[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
   end

   assign found = |vec;

endmodule

// File: rtl/core/stack_graph_traversal.sv
// stack_graph_traversal: depth-first search over an adjacency matrix in memory.
// Depends on sgt_pkg, sgt_req_if, sgt_rsp_if and sgt_msb_pick.
//
//   channel   dir  beat contents
//   req_beat  in   kind, row_index, row_bits, start_vertex
//   rsp_beat  out  vertex, last, bad_start
//   csr       in   vertex_count write (csr_wr_en, csr_wr_data)
//
// A row load is written from idle; a bad start answers through S_BAD. A good
// start pushes the start vertex; then each vertex is popped, its row read, its
// new neighbors pushed and it is sent. The pace is set by the stack read ->
// adjacency read chain and by the single stack write port, one push per cycle.
// Reset is synchronous; row and stack memories are not cleared.
// Responses go out through a register; a stalled sink holds the scan at its end.

module stack_graph_traversal #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [sgt_pkg::COUNT_W-1:0] csr_wr_data,
   sgt_req_if.sink                     req_beat,
   sgt_rsp_if.source                   rsp_beat
);
   import sgt_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int DEP_W = $clog2(MAX_VERTICES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BAD   = 3'd1;
   localparam logic [2:0] S_POP   = 3'd2;
   localparam logic [2:0] S_RDADJ = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_SCAN  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [COUNT_W-1:0]      vertex_count_ff, vertex_count_in;
   logic [DEP_W-1:0]        depth_ff, depth_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [MAX_VERTICES-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0]        cur_ff, cur_in;
   logic [VERTEX_W-1:0]     start_ff, start_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // memories
   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [IDX_W-1:0]        stack_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic [IDX_W-1:0]        stack_rd_ff;

   logic                    adj_we;
   logic [IDX_W-1:0]        adj_waddr;
   logic [IDX_W-1:0]        adj_raddr;
   logic                    stack_we;
   logic [IDX_W-1:0]        stack_waddr;
   logic [IDX_W-1:0]        stack_wdata;
   logic [IDX_W-1:0]        stack_raddr;

   logic [COUNT_W-1:0]      eff_count;
   logic [MAX_VERTICES-1:0] count_mask;
   logic [MAX_VERTICES-1:0] cand_new;
   logic                    out_free;
   logic [IDX_W-1:0]        pick_idx;
   logic                    pick_found;

   assign eff_count = (vertex_count_ff > COUNT_W'(MAX_VERTICES)) ?
                      COUNT_W'(MAX_VERTICES) : vertex_count_ff;

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         count_mask[i] = COUNT_W'(i) < eff_count;
      end
   end

   assign cand_new    = adj_rd_ff & ~visited_ff & count_mask;
   assign out_free    = !rsp_valid_ff || rsp_beat.ready;
   assign adj_waddr   = req_beat.data.row_index[IDX_W-1:0];
   assign adj_raddr   = stack_rd_ff;
   assign stack_raddr = IDX_W'(depth_ff - DEP_W'(1));

   sgt_msb_pick #(
      .WIDTH (MAX_VERTICES)
   ) u_pick (
      .vec   (cand_ff),
      .idx   (pick_idx),
      .found (pick_found)
   );

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= req_beat.data.row_bits[MAX_VERTICES-1:0];
      end
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   always_comb begin
      state_in        = state_ff;
      vertex_count_in = vertex_count_ff;
      depth_in        = depth_ff;
      visited_in      = visited_ff;
      cand_in         = cand_ff;
      cur_in          = cur_ff;
      start_in        = start_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_beat.ready;
      rsp_data_in     = rsp_data_ff;
      adj_we          = 1'b0;
      stack_we        = 1'b0;
      stack_waddr     = depth_ff[IDX_W-1:0];
      stack_wdata     = pick_idx;

      if (csr_wr_en) begin
         vertex_count_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat.valid) begin
               if (req_beat.data.kind == KIND_ROW) begin
                  adj_we = {1'b0, req_beat.data.row_index} < (VERTEX_W + 1)'(MAX_VERTICES);
               end else if ({1'b0, req_beat.data.start_vertex} >= eff_count) begin
                  start_in = req_beat.data.start_vertex;
                  state_in = S_BAD;
               end else begin
                  visited_in = '0;
                  visited_in[req_beat.data.start_vertex[IDX_W-1:0]] = 1'b1;
                  stack_we    = 1'b1;
                  stack_waddr = '0;
                  stack_wdata = req_beat.data.start_vertex[IDX_W-1:0];
                  depth_in    = DEP_W'(1);
                  state_in    = S_POP;
               end
            end
         end
         S_BAD: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.vertex    = start_ff;
               rsp_data_in.last      = 1'b1;
               rsp_data_in.bad_start = 1'b1;
               state_in              = S_IDLE;
            end
         end
         S_POP: begin
            depth_in = depth_ff - DEP_W'(1);
            state_in = S_RDADJ;
         end
         S_RDADJ: begin
            cur_in   = stack_rd_ff;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // all unvisited neighbors get marked now; pushes follow one a cycle
            cand_in    = cand_new;
            visited_in = visited_ff | cand_new;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (pick_found) begin
               stack_we          = 1'b1;
               depth_in          = depth_ff + DEP_W'(1);
               cand_in[pick_idx] = 1'b0;
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.vertex    = VERTEX_W'(cur_ff);
               rsp_data_in.last      = depth_ff == '0;
               rsp_data_in.bad_start = 1'b0;
               state_in              = (depth_ff == '0) ? S_IDLE : S_POP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vertex_count_ff <= COUNT_RESET;
         depth_ff        <= '0;
         visited_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vertex_count_ff <= vertex_count_in;
         depth_ff        <= depth_in;
         visited_ff      <= visited_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_beat.ready = state_ff == S_IDLE;
   assign rsp_beat.valid = rsp_valid_ff;
   assign rsp_beat.data  = rsp_data_ff;

endmodule
